// ----- rtl/tgd_pkg.sv -----
package tgd_pkg;

  localparam int unsigned MaxSide = 8;
  localparam int unsigned Cells   = MaxSide * MaxSide;
  localparam int unsigned AddrW   = $clog2(Cells);
  localparam int unsigned CountW  = $clog2(Cells + 1);
  localparam int unsigned SideW   = 4;
  localparam int unsigned CoordW  = $clog2(MaxSide);
  localparam int unsigned ByteW   = 8;

  typedef enum logic [2:0] {
    StLoad,
    StScan,
    StFinish,
    StEmit,
    StInvalid
  } state_e;

  // Side length as used by the grid: zero counts as one, anything above the
  // largest grid is clamped to it.
  function automatic logic [SideW-1:0] eff_side(input logic [SideW-1:0] side);
    logic [SideW-1:0] n;
    n = side;
    if (n == '0) begin
      n = SideW'(1);
    end
    if (n > SideW'(MaxSide)) begin
      n = SideW'(MaxSide);
    end
    return n;
  endfunction

  // Number of cells in an n by n grid.
  function automatic logic [CountW-1:0] side_cells(input logic [SideW-1:0] n);
    logic [2*SideW-1:0] prod;
    prod = {{SideW{1'b0}}, n} * {{SideW{1'b0}}, n};
    return prod[CountW-1:0];
  endfunction

  // Row-major address of cell (i, j) in a grid of side n.
  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] i,
                                                 input logic [CoordW-1:0] j,
                                                 input logic [SideW-1:0]  n);
    logic [CoordW+SideW-1:0] prod;
    prod = {{SideW{1'b0}}, i} * {{CoordW{1'b0}}, n}
         + {{SideW{1'b0}}, j};
    return prod[AddrW-1:0];
  endfunction

endpackage

// ----- rtl/turning_grille_decoder.sv -----
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ----------------------------------
// input     in         in_valid_i / in_ready_o      hole_i, cipher_byte_i
// output    out        out_valid_o / out_ready_i    plain_byte_o, invalid_o, last_o
// config    in         cfg_we_i (no wait)           cfg_side_i
//
// Loading takes one input transaction per cell; an n by n grid needs n*n of them.
// The decode scan then visits every cell once for each of the four grille positions,
// one cell per cycle through the hole and ciphertext memories.
// Plaintext leaves the plaintext memory at one byte per cycle when the sink keeps up.
// Reset is asynchronous and active low; it empties the output register, sets the
// side to eight and needs no clearing pass, as the coverage flags are flip-flops.
// A stalled sink holds the output register; once the last result is in it, the next grid may load.
module turning_grille_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tgd_pkg::SideW-1:0]  cfg_side_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       hole_i,
  input  logic [tgd_pkg::ByteW-1:0]  cipher_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tgd_pkg::ByteW-1:0]  plain_byte_o,
  output logic                       invalid_o,
  output logic                       last_o
);
  import tgd_pkg::*;

  // Configuration and derived grid geometry.
  logic [SideW-1:0]  side_q;
  logic [SideW-1:0]  n_side;
  logic [CoordW-1:0] n_m1;
  logic [CountW-1:0] total;

  // Controller state.
  state_e            state_q, state_d;
  logic [CountW-1:0] load_cnt_q, load_cnt_d;
  logic [1:0]        turn_q, turn_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [CoordW-1:0] col_q, col_d;
  logic [CountW-1:0] ci_q, ci_d;
  logic              fail_q, fail_d;
  logic [CountW-1:0] em_cnt_q, em_cnt_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              s1_valid_q, s1_valid_d;
  logic [AddrW-1:0]  s1_dst_q;
  logic [Cells-1:0]  covered_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_plain_q, out_plain_d;
  logic              out_invalid_q, out_invalid_d;
  logic              out_last_q, out_last_d;

  // Memories and their registered read data.
  logic             hole_mem   [Cells];
  logic [ByteW-1:0] cipher_mem [Cells];
  logic [ByteW-1:0] plain_mem  [Cells];
  logic             hole_rd_q;
  logic [ByteW-1:0] cipher_rd_q;
  logic [ByteW-1:0] plain_rd_q;

  // Scan datapath.
  logic [CoordW-1:0] src_i, src_j;
  logic [AddrW-1:0]  src_addr;
  logic [AddrW-1:0]  dst_addr;
  logic              hit, overlap, take;
  logic [CountW-1:0] ci_next;
  logic              in_fire, scan_start, rd_issue, move, last_cell;

  assign n_side = eff_side(side_q);
  assign n_m1   = CoordW'(n_side - SideW'(1));
  assign total  = side_cells(n_side);

  assign in_ready_o = (state_q == StLoad);
  assign in_fire    = in_valid_i && in_ready_o;

  // Source cell of the grille that lies over (row, col) after the given number of
  // clockwise quarter turns.
  always_comb begin
    unique case (turn_q)
      2'd0: begin
        src_i = row_q;
        src_j = col_q;
      end
      2'd1: begin
        src_i = n_m1 - col_q;
        src_j = row_q;
      end
      2'd2: begin
        src_i = n_m1 - row_q;
        src_j = n_m1 - col_q;
      end
      default: begin
        src_i = col_q;
        src_j = n_m1 - row_q;
      end
    endcase
  end

  assign src_addr = cell_addr(src_i, src_j, n_side);
  assign dst_addr = cell_addr(row_q, col_q, n_side);

  // Second scan stage: the hole bit and the candidate ciphertext byte have arrived.
  // A cell that is already covered is an overlap; otherwise the byte is consumed,
  // and the ciphertext read issued in this same cycle already points past it.
  assign hit     = s1_valid_q && hole_rd_q;
  assign overlap = hit && covered_q[s1_dst_q];
  assign take    = hit && !covered_q[s1_dst_q];
  assign ci_next = ci_q + CountW'(take);

  assign last_cell = (turn_q == 2'd3) && (row_q == n_m1) && (col_q == n_m1);

  // The output register is refilled from the plaintext read data whenever it is
  // free or being emptied in this cycle.
  assign move = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    load_cnt_d    = load_cnt_q;
    turn_d        = turn_q;
    row_d         = row_q;
    col_d         = col_q;
    ci_d          = ci_next;
    fail_d        = fail_q || overlap;
    em_cnt_d      = em_cnt_q;
    pend_d        = pend_q;
    pend_last_d   = pend_last_q;
    s1_valid_d    = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_plain_d   = out_plain_q;
    out_invalid_d = out_invalid_q;
    out_last_d    = out_last_q;
    scan_start    = 1'b0;
    rd_issue      = 1'b0;

    if (move) begin
      out_valid_d   = 1'b1;
      out_plain_d   = plain_rd_q;
      out_invalid_d = 1'b0;
      out_last_d    = pend_last_q;
      pend_d        = 1'b0;
    end

    unique case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (load_cnt_q == total - CountW'(1)) begin
            load_cnt_d = '0;
            scan_start = 1'b1;
            turn_d     = '0;
            row_d      = '0;
            col_d      = '0;
            ci_d       = '0;
            fail_d     = 1'b0;
            state_d    = StScan;
          end else begin
            load_cnt_d = load_cnt_q + CountW'(1);
          end
        end
      end
      StScan: begin
        s1_valid_d = 1'b1;
        if (col_q == n_m1) begin
          col_d = '0;
          if (row_q == n_m1) begin
            row_d  = '0;
            turn_d = turn_q + 2'd1;
          end else begin
            row_d = row_q + CoordW'(1);
          end
        end else begin
          col_d = col_q + CoordW'(1);
        end
        if (last_cell) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        // Without an overlap every consumed byte covered a new cell, so the grid
        // is fully covered exactly when all of its bytes were consumed.
        em_cnt_d = '0;
        if (fail_q || overlap || (ci_next != total)) begin
          state_d = StInvalid;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        rd_issue = (em_cnt_q != total) && (!pend_q || move);
        if (rd_issue) begin
          em_cnt_d    = em_cnt_q + CountW'(1);
          pend_d      = 1'b1;
          pend_last_d = (em_cnt_q == total - CountW'(1));
        end
        if ((em_cnt_q == total) && (!pend_q || move)) begin
          state_d = StLoad;
        end
      end
      StInvalid: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_plain_d   = '0;
          out_invalid_d = 1'b1;
          out_last_d    = 1'b1;
          state_d       = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase

    // A new side drops any partly loaded grid.
    if (cfg_we_i) begin
      load_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      side_q      <= SideW'(MaxSide);
      load_cnt_q  <= '0;
      turn_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      ci_q        <= '0;
      fail_q      <= 1'b0;
      em_cnt_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      covered_q   <= '0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      turn_q      <= turn_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ci_q        <= ci_d;
      fail_q      <= fail_d;
      em_cnt_q    <= em_cnt_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        side_q <= cfg_side_i;
      end
      if (scan_start) begin
        covered_q <= '0;
      end else if (take) begin
        covered_q[s1_dst_q] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s1_dst_q      <= dst_addr;
    out_plain_q   <= out_plain_d;
    out_invalid_q <= out_invalid_d;
    out_last_q    <= out_last_d;
  end

  // Hole and ciphertext memories: written while loading, read once per scan cycle.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hole_mem[load_cnt_q[AddrW-1:0]]   <= hole_i;
      cipher_mem[load_cnt_q[AddrW-1:0]] <= cipher_byte_i;
    end
    hole_rd_q   <= hole_mem[src_addr];
    cipher_rd_q <= cipher_mem[ci_next[AddrW-1:0]];
  end

  // Plaintext memory: written by the scan, read in row-major order while emitting.
  always_ff @(posedge clk_i) begin
    if (take) begin
      plain_mem[s1_dst_q] <= cipher_rd_q;
    end
    if (rd_issue) begin
      plain_rd_q <= plain_mem[em_cnt_q[AddrW-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = out_plain_q;
  assign invalid_o    = out_invalid_q;
  assign last_o       = out_last_q;

`ifndef NO_ASSERTIONS
  a_pend_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == StEmit))
    else $error("plaintext read data pending outside the emit phase");

  a_stage1_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ((state_q == StScan) || (state_q == StFinish)))
    else $error("scan stage active outside the scan");

  a_load_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> (load_cnt_q < total))
    else $error("load count beyond the grid");

  a_invalid_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |-> (last_o && (plain_byte_o == '0)))
    else $error("invalid result not a single zero transaction");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (em_cnt_q <= total))
    else $error("emit count beyond the grid");
`endif

endmodule
